FILE: rtl/mlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_pkg
// Shared types and constants of the learning bridge table.
// ----------------------------------------------------------------------------
package mlb_pkg;

    localparam int unsigned DYN_ENTRIES_DEF    = 1024;
    localparam int unsigned STATIC_ENTRIES_DEF = 64;

    localparam int unsigned MAC_W   = 48;
    localparam int unsigned PORT_W  = 8;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned CNT_W   = 11;

    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;

    localparam logic OP_FRAME  = 1'b0;
    localparam logic OP_STATIC = 1'b1;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STATIC,
        ST_DYN,
        ST_LEARN,
        ST_DONE
    } state_t;

    // one dynamic table row
    typedef struct packed {
        logic               valid;
        logic [MAC_W-1:0]   mac;
        logic [PORT_W-1:0]  port;
        logic [STAMP_W-1:0] stamp;
    } dyn_entry_t;

    // one static table row
    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic              filter;
        logic [PORT_W-1:0] target;
    } static_entry_t;

    // per-row compare results of the dynamic table
    typedef struct packed {
        logic live;
        logic aged;
        logic src_hit;
        logic dst_hit;
    } dyn_eval_t;

    // per-row compare results of the static table
    typedef struct packed {
        logic              src_hit;
        logic              dst_hit;
        logic              filter;
        logic [PORT_W-1:0] target;
    } static_eval_t;

endpackage
`default_nettype wire

FILE: rtl/mlb_static_tbl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_static_tbl
// Static rule memory with per-row valid flops and key compare on read data.
// ----------------------------------------------------------------------------
module mlb_static_tbl #(
    parameter int unsigned STATIC_ENTRIES = mlb_pkg::STATIC_ENTRIES_DEF,
    localparam int unsigned SAW = (STATIC_ENTRIES > 1) ? $clog2(STATIC_ENTRIES) : 1
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           wr_en,
    input  wire  [SAW-1:0]                wr_slot,
    input  wire  mlb_pkg::static_entry_t  wr_data,
    input  wire  [SAW-1:0]                rd_addr,
    input  wire  [mlb_pkg::MAC_W-1:0]     src_mac,
    input  wire  [mlb_pkg::MAC_W-1:0]     dst_mac,
    input  wire  [mlb_pkg::PORT_W-1:0]    key_port,
    output mlb_pkg::static_eval_t         eval
);

    logic [STATIC_ENTRIES-1:0] valid_reg;
    logic                      rd_live_reg;
    mlb_pkg::static_entry_t    mem [STATIC_ENTRIES];
    mlb_pkg::static_entry_t    rd_data_reg;

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            rd_live_reg <= valid_reg[rd_addr];
        end
    end

    // rule memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // key compare
    always_comb
    begin
        eval.src_hit = rd_live_reg && (rd_data_reg.mac == src_mac)
                       && (rd_data_reg.port == key_port);
        eval.dst_hit = rd_live_reg && (rd_data_reg.mac == dst_mac)
                       && (rd_data_reg.port == key_port);
        eval.filter  = rd_data_reg.filter;
        eval.target  = rd_data_reg.target;
    end

endmodule
`default_nettype wire

FILE: rtl/mlb_dyn_tbl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_dyn_tbl
// Learned address memory with age check and MAC compare on read data.
// ----------------------------------------------------------------------------
module mlb_dyn_tbl #(
    parameter int unsigned DYN_ENTRIES = mlb_pkg::DYN_ENTRIES_DEF,
    localparam int unsigned DAW = (DYN_ENTRIES > 1) ? $clog2(DYN_ENTRIES) : 1
) (
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire  [DAW-1:0]               wr_addr,
    input  wire  mlb_pkg::dyn_entry_t    wr_data,
    input  wire  [DAW-1:0]               rd_addr,
    input  wire                          age_en,
    input  wire  [mlb_pkg::STAMP_W-1:0]  age_limit,
    input  wire  [mlb_pkg::MAC_W-1:0]    src_mac,
    input  wire  [mlb_pkg::MAC_W-1:0]    dst_mac,
    output mlb_pkg::dyn_entry_t          rd_data,
    output mlb_pkg::dyn_eval_t           eval
);

    mlb_pkg::dyn_entry_t mem [DYN_ENTRIES];
    mlb_pkg::dyn_entry_t rd_data_reg;

    // table memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

    // aging and compare on the row just read
    always_comb
    begin
        eval.aged    = rd_data_reg.valid && age_en && (rd_data_reg.stamp < age_limit);
        eval.live    = rd_data_reg.valid && !eval.aged;
        eval.src_hit = eval.live && (rd_data_reg.mac == src_mac);
        eval.dst_hit = eval.live && (rd_data_reg.mac == dst_mac);
    end

endmodule
`default_nettype wire

FILE: rtl/mac_learning_bridge_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Frame item: one pass over each table memory (one row per cycle through its
// read port), then a learn step, before the result. Static write item:
// written at accept, no sweep. One item at a time. Reset: after rst_n rises
// a clearing pass over all DYN_ENTRIES rows empties the learned table; no
// item is accepted during it, configuration writes are.
// ----------------------------------------------------------------------------
// mac_learning_bridge_table_top
// Learning bridge: aging, source learning and forwarding decision.
// ----------------------------------------------------------------------------
module mac_learning_bridge_table_top #(
    parameter int unsigned DYN_ENTRIES    = mlb_pkg::DYN_ENTRIES_DEF,
    parameter int unsigned STATIC_ENTRIES = mlb_pkg::STATIC_ENTRIES_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // configuration
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [mlb_pkg::STAMP_W-1:0]   expiry_time,
    // input items
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire                           op,
    input  wire  [mlb_pkg::MAC_W-1:0]     src_mac,
    input  wire  [mlb_pkg::MAC_W-1:0]     dst_mac,
    input  wire  [mlb_pkg::PORT_W-1:0]    in_port,
    input  wire  [mlb_pkg::STAMP_W-1:0]   now,
    input  wire  [mlb_pkg::SLOT_W-1:0]    static_slot,
    input  wire  [mlb_pkg::PORT_W-1:0]    static_target,
    input  wire                           static_filter,
    // result items
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic [mlb_pkg::PORT_W-1:0]    out_port,
    output logic                          flood,
    output logic                          filtered,
    output logic                          table_full,
    output logic [mlb_pkg::CNT_W-1:0]     expired_count
);

    localparam int unsigned DAW  = (DYN_ENTRIES > 1) ? $clog2(DYN_ENTRIES) : 1;
    localparam int unsigned SAW  = (STATIC_ENTRIES > 1) ? $clog2(STATIC_ENTRIES) : 1;
    localparam int unsigned MAXE = (DYN_ENTRIES > STATIC_ENTRIES) ? DYN_ENTRIES
                                                                  : STATIC_ENTRIES;
    localparam int unsigned CW   = $clog2(MAXE + 1) + 1;
    localparam int unsigned XW   = mlb_pkg::SLOT_W + SAW;

    localparam logic [CW-1:0] DYN_N    = CW'(DYN_ENTRIES);
    localparam logic [CW-1:0] STATIC_N = CW'(STATIC_ENTRIES);

    mlb_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           rd_vld_reg, rd_vld_next;
    logic [CW-1:0]  rd_idx_reg, rd_idx_next;

    logic [mlb_pkg::STAMP_W-1:0] expiry_reg;

    // latched frame
    logic [mlb_pkg::MAC_W-1:0]   src_reg, src_next;
    logic [mlb_pkg::MAC_W-1:0]   dst_reg, dst_next;
    logic [mlb_pkg::PORT_W-1:0]  port_reg, port_next;
    logic [mlb_pkg::STAMP_W-1:0] now_reg, now_next;
    logic                        age_en_reg, age_en_next;
    logic [mlb_pkg::STAMP_W-1:0] limit_reg, limit_next;

    // sweep results
    logic                        s_src_reg, s_src_next;
    logic                        s_dst_reg, s_dst_next;
    logic                        s_filter_reg, s_filter_next;
    logic [mlb_pkg::PORT_W-1:0]  s_target_reg, s_target_next;
    logic                        d_src_reg, d_src_next;
    logic [DAW-1:0]              d_src_idx_reg, d_src_idx_next;
    logic [mlb_pkg::PORT_W-1:0]  d_src_port_reg, d_src_port_next;
    logic                        d_free_reg, d_free_next;
    logic [DAW-1:0]              d_free_idx_reg, d_free_idx_next;
    logic                        d_dst_reg, d_dst_next;
    logic [mlb_pkg::PORT_W-1:0]  d_dst_port_reg, d_dst_port_next;
    logic [mlb_pkg::CNT_W-1:0]   aged_reg, aged_next;

    // pending result
    logic [mlb_pkg::PORT_W-1:0]  r_port_reg, r_port_next;
    logic                        r_flood_reg, r_flood_next;
    logic                        r_filt_reg, r_filt_next;
    logic                        r_full_reg, r_full_next;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic [mlb_pkg::PORT_W-1:0]  out_port_reg, out_port_next;
    logic                        flood_reg, flood_next;
    logic                        filt_reg, filt_next;
    logic                        full_reg, full_next;
    logic [mlb_pkg::CNT_W-1:0]   count_reg, count_next;

    logic                        in_accept;
    logic                        out_load;
    logic [XW-1:0]               slot_ext;
    logic                        slot_ok;

    // memory ports
    logic                        st_wr_en;
    mlb_pkg::static_entry_t      st_wr_data;
    mlb_pkg::static_eval_t       st_eval;
    logic                        dy_wr_en;
    logic [DAW-1:0]              dy_wr_addr;
    mlb_pkg::dyn_entry_t         dy_wr_data;
    mlb_pkg::dyn_entry_t         dy_rd_data;
    mlb_pkg::dyn_eval_t          dy_eval;

    logic                        issue;
    logic                        last_static;
    logic                        last_dyn;
    logic                        learn_new;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != mlb_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == mlb_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    assign slot_ext = {{SAW{1'b0}}, static_slot};
    assign slot_ok  = (slot_ext < XW'(STATIC_ENTRIES));

    assign issue       = ((state_reg == mlb_pkg::ST_STATIC) && (cnt_reg < STATIC_N))
                      || ((state_reg == mlb_pkg::ST_DYN) && (cnt_reg < DYN_N));
    assign last_static = (state_reg == mlb_pkg::ST_STATIC) && rd_vld_reg
                      && (rd_idx_reg == STATIC_N - CW'(1));
    assign last_dyn    = (state_reg == mlb_pkg::ST_DYN) && rd_vld_reg
                      && (rd_idx_reg == DYN_N - CW'(1));
    assign learn_new   = !s_src_reg && !d_src_reg && d_free_reg;

    // static rule write
    assign st_wr_en          = in_accept && (op == mlb_pkg::OP_STATIC) && slot_ok;
    assign st_wr_data.mac    = dst_mac;
    assign st_wr_data.port   = in_port;
    assign st_wr_data.filter = static_filter;
    assign st_wr_data.target = static_target;

    mlb_static_tbl #(
        .STATIC_ENTRIES (STATIC_ENTRIES)
    ) u_static (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (st_wr_en),
        .wr_slot  (slot_ext[SAW-1:0]),
        .wr_data  (st_wr_data),
        .rd_addr  (cnt_reg[SAW-1:0]),
        .src_mac  (src_reg),
        .dst_mac  (dst_reg),
        .key_port (port_reg),
        .eval     (st_eval)
    );

    mlb_dyn_tbl #(
        .DYN_ENTRIES (DYN_ENTRIES)
    ) u_dyn (
        .clk       (clk),
        .wr_en     (dy_wr_en),
        .wr_addr   (dy_wr_addr),
        .wr_data   (dy_wr_data),
        .rd_addr   (cnt_reg[DAW-1:0]),
        .age_en    (age_en_reg),
        .age_limit (limit_reg),
        .src_mac   (src_reg),
        .dst_mac   (dst_reg),
        .rd_data   (dy_rd_data),
        .eval      (dy_eval)
    );

    // dynamic table write: clearing pass, aging, learning
    always_comb
    begin
        dy_wr_en   = 1'b0;
        dy_wr_addr = cnt_reg[DAW-1:0];
        dy_wr_data = '0;
        case (state_reg)
            mlb_pkg::ST_CLEAR:
            begin
                dy_wr_en = 1'b1;
            end
            mlb_pkg::ST_DYN:
            begin
                dy_wr_en         = rd_vld_reg && dy_eval.aged;
                dy_wr_addr       = rd_idx_reg[DAW-1:0];
                dy_wr_data       = dy_rd_data;
                dy_wr_data.valid = 1'b0;
            end
            mlb_pkg::ST_LEARN:
            begin
                dy_wr_en         = !s_src_reg && (d_src_reg || d_free_reg);
                dy_wr_addr       = d_src_reg ? d_src_idx_reg : d_free_idx_reg;
                dy_wr_data.valid = 1'b1;
                dy_wr_data.mac   = src_reg;
                dy_wr_data.port  = d_src_reg ? d_src_port_reg : port_reg;
                dy_wr_data.stamp = now_reg;
            end
            default:
            begin
                dy_wr_en = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlb_pkg::ST_CLEAR:
            begin
                if (cnt_reg == DYN_N - CW'(1))
                begin
                    state_next = mlb_pkg::ST_IDLE;
                end
            end
            mlb_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (op == mlb_pkg::OP_STATIC) ? mlb_pkg::ST_DONE
                                                            : mlb_pkg::ST_STATIC;
                end
            end
            mlb_pkg::ST_STATIC:
            begin
                if (last_static)
                begin
                    state_next = mlb_pkg::ST_DYN;
                end
            end
            mlb_pkg::ST_DYN:
            begin
                if (last_dyn)
                begin
                    state_next = mlb_pkg::ST_LEARN;
                end
            end
            mlb_pkg::ST_LEARN:
            begin
                state_next = mlb_pkg::ST_DONE;
            end
            mlb_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = mlb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mlb_pkg::ST_IDLE;
            end
        endcase
    end

    // sweep counters and accumulated results
    always_comb
    begin
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        port_next       = port_reg;
        now_next        = now_reg;
        age_en_next     = age_en_reg;
        limit_next      = limit_reg;
        s_src_next      = s_src_reg;
        s_dst_next      = s_dst_reg;
        s_filter_next   = s_filter_reg;
        s_target_next   = s_target_reg;
        d_src_next      = d_src_reg;
        d_src_idx_next  = d_src_idx_reg;
        d_src_port_next = d_src_port_reg;
        d_free_next     = d_free_reg;
        d_free_idx_next = d_free_idx_reg;
        d_dst_next      = d_dst_reg;
        d_dst_port_next = d_dst_port_reg;
        aged_next       = aged_reg;
        r_port_next     = r_port_reg;
        r_flood_next    = r_flood_reg;
        r_filt_next     = r_filt_reg;
        r_full_next     = r_full_reg;

        if (issue)
        begin
            cnt_next    = cnt_reg + CW'(1);
            rd_vld_next = 1'b1;
            rd_idx_next = cnt_reg;
        end

        case (state_reg)
            mlb_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == DYN_N - CW'(1))
                begin
                    cnt_next = '0;
                end
            end
            mlb_pkg::ST_IDLE:
            begin
                cnt_next        = '0;
                src_next        = src_mac;
                dst_next        = dst_mac;
                port_next       = in_port;
                now_next        = now;
                age_en_next     = (now >= expiry_reg);
                limit_next      = now - expiry_reg;
                s_src_next      = 1'b0;
                s_dst_next      = 1'b0;
                d_src_next      = 1'b0;
                d_free_next     = 1'b0;
                d_dst_next      = 1'b0;
                aged_next       = '0;
                r_port_next     = '0;
                r_flood_next    = 1'b0;
                r_filt_next     = 1'b0;
                r_full_next     = 1'b0;
            end
            mlb_pkg::ST_STATIC:
            begin
                if (rd_vld_reg)
                begin
                    s_src_next = s_src_reg || st_eval.src_hit;
                    if (!s_dst_reg && st_eval.dst_hit)
                    begin
                        s_dst_next    = 1'b1;
                        s_filter_next = st_eval.filter;
                        s_target_next = st_eval.target;
                    end
                end
                if (last_static)
                begin
                    cnt_next    = '0;
                    rd_vld_next = 1'b0;
                end
            end
            mlb_pkg::ST_DYN:
            begin
                if (rd_vld_reg)
                begin
                    if (dy_eval.aged && (aged_reg != mlb_pkg::CNT_MAX))
                    begin
                        aged_next = aged_reg + mlb_pkg::CNT_W'(1);
                    end
                    if (!d_src_reg && dy_eval.src_hit)
                    begin
                        d_src_next      = 1'b1;
                        d_src_idx_next  = rd_idx_reg[DAW-1:0];
                        d_src_port_next = dy_rd_data.port;
                    end
                    if (!d_free_reg && !dy_eval.live)
                    begin
                        d_free_next     = 1'b1;
                        d_free_idx_next = rd_idx_reg[DAW-1:0];
                    end
                    if (!d_dst_reg && dy_eval.dst_hit)
                    begin
                        d_dst_next      = 1'b1;
                        d_dst_port_next = dy_rd_data.port;
                    end
                end
            end
            mlb_pkg::ST_LEARN:
            begin
                r_full_next = !s_src_reg && !d_src_reg && !d_free_reg;
                if (s_dst_reg)
                begin
                    r_filt_next = s_filter_reg;
                    r_port_next = s_filter_reg ? port_reg : s_target_reg;
                end
                else if (d_dst_reg)
                begin
                    r_port_next = d_dst_port_reg;
                end
                else if (learn_new && (dst_reg == src_reg))
                begin
                    r_port_next = port_reg;
                end
                else
                begin
                    r_flood_next = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_port_next  = out_port_reg;
        flood_next     = flood_reg;
        filt_next      = filt_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_port_next  = r_port_reg;
            flood_next     = r_flood_reg;
            filt_next      = r_filt_reg;
            full_next      = r_full_reg;
            count_next     = aged_reg;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlb_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            expiry_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                expiry_reg <= expiry_time;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        port_reg       <= port_next;
        now_reg        <= now_next;
        age_en_reg     <= age_en_next;
        limit_reg      <= limit_next;
        s_src_reg      <= s_src_next;
        s_dst_reg      <= s_dst_next;
        s_filter_reg   <= s_filter_next;
        s_target_reg   <= s_target_next;
        d_src_reg      <= d_src_next;
        d_src_idx_reg  <= d_src_idx_next;
        d_src_port_reg <= d_src_port_next;
        d_free_reg     <= d_free_next;
        d_free_idx_reg <= d_free_idx_next;
        d_dst_reg      <= d_dst_next;
        d_dst_port_reg <= d_dst_port_next;
        aged_reg       <= aged_next;
        r_port_reg     <= r_port_next;
        r_flood_reg    <= r_flood_next;
        r_filt_reg     <= r_filt_next;
        r_full_reg     <= r_full_next;
        out_port_reg   <= out_port_next;
        flood_reg      <= flood_next;
        filt_reg       <= filt_next;
        full_reg       <= full_next;
        count_reg      <= count_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_port      = out_port_reg;
    assign flood         = flood_reg;
    assign filtered      = filt_reg;
    assign table_full    = full_reg;
    assign expired_count = count_reg;

endmodule
`default_nettype wire

FILE: rtl/mlb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlb_checker
// Port-level checks of the bridge table, bound to the top level.
// ----------------------------------------------------------------------------
module mlb_checker (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        in_valid,
    input wire                        in_stall,
    input wire                        out_valid,
    input wire                        out_stall,
    input wire [mlb_pkg::PORT_W-1:0]  out_port,
    input wire                        flood,
    input wire                        filtered
);

    // a held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // one item at a time: an accepted item makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted back to back");

    // a flooded frame carries no port and no filter
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && flood |-> (out_port == '0) && !filtered)
        else $error("flood result with port or filter set");

    // a result only follows an accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(in_stall))
        else $error("result without an item in work");

endmodule

bind mac_learning_bridge_table_top mlb_checker u_mlb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_port  (out_port),
    .flood     (flood),
    .filtered  (filtered)
);
`default_nettype wire
